// ===== design/hid_keyboard_report_builder_top_macros.svh =====
// Assertion macros for the keyboard report builder modules.
`ifndef HID_KEYBOARD_REPORT_BUILDER_TOP_MACROS_SVH
`define HID_KEYBOARD_REPORT_BUILDER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge of clk while arst_n is high.
`define HKRB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check a property on every rising edge of clk, reset included.
`define HKRB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HKRB_ASSERT(lbl, prop, msg)
`define HKRB_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== design/hkrb_pkg.sv =====
// Types, constants and key translation shared by the keyboard report builder.
package hkrb_pkg;

	localparam int SLOT_COUNT   = 6;
	localparam int SHOWN_SLOTS  = 6;
	localparam int REPORT_DEPTH = 4;
	localparam int PTR_W        = $clog2(REPORT_DEPTH);
	localparam int CNT_W        = $clog2(REPORT_DEPTH + 1);

	localparam logic [4:0] MOD_CODE_HI = 5'b10000;
	localparam logic [7:0] SHIFT_BIT   = 8'h02;

	typedef enum logic [1:0] {
		REQ_PRESS       = 2'd0,
		REQ_RELEASE     = 2'd1,
		REQ_RELEASE_ALL = 2'd2,
		REQ_TAP         = 2'd3
	} req_t;

	typedef logic [7:0] usage_t;

	typedef struct packed {
		logic                         last;
		usage_t [SHOWN_SLOTS-1:0]     slot;
		logic [7:0]                   modifier;
	} report_t;

	typedef struct packed {
		logic [1:0] n;
		report_t    first;
		report_t    second;
	} push_t;

	function automatic usage_t usage_of(input logic [7:0] k);
		usage_t u;
		u = '0;
		case (k) inside
			[8'hC2:8'hCD]: u = 8'h3A + (k - 8'hC2);
			8'hC1:         u = 8'h39;
			[8'hCE:8'hD6]: u = 8'h46 + (k - 8'hCE);
			[8'hD7:8'hDA]: u = 8'h4F + (k - 8'hD7);
			[8'hB0:8'hB3]: u = 8'h28 + (k - 8'hB0);
			[8'h61:8'h7A]: u = 8'h04 + (k - 8'h61);
			[8'h41:8'h5A]: u = 8'h04 + (k - 8'h41);
			8'h30:         u = 8'h27;
			[8'h31:8'h39]: u = 8'h1E + (k - 8'h31);
			8'h20:         u = 8'h2C;
			8'h2D:         u = 8'h2D;
			8'h3D:         u = 8'h2E;
			8'h5B:         u = 8'h2F;
			8'h5D:         u = 8'h30;
			8'h5C:         u = 8'h31;
			8'h3B:         u = 8'h33;
			8'h27:         u = 8'h34;
			8'h60:         u = 8'h35;
			8'h2C:         u = 8'h36;
			8'h2E:         u = 8'h37;
			8'h2F:         u = 8'h38;
			default:       u = '0;
		endcase
		return u;
	endfunction

endpackage

// ===== design/hid_keyboard_report_builder_top.sv =====
// Top level of the USB boot keyboard report builder.
// A request is registered first; once the report queue has room, its reports are written in and offered from there.
// Throughput: one request per cycle while the four-entry report queue has room for two.
// A tap of a known key yields two reports, an unknown key none, and the output side moves one report per transfer.
// Reset (arst_n low) clears the modifier byte, all key slots and the report queue.
module hid_keyboard_report_builder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,    // key_code
	input  logic [1:0]  s_tuser,    // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,    // modifier_bits, slot0_usage .. slot5_usage
	output logic        m_tlast     // last_of_run
);

	logic             valid_s1;
	hkrb_pkg::req_t   req_s1;
	logic [7:0]       key_s1;
	logic             room;
	logic             advance;
	hkrb_pkg::push_t  push;

	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1 <= hkrb_pkg::req_t'(s_tuser);
			key_s1 <= s_tdata;
		end
	end

	hkrb_engine u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.req     (req_s1),
		.key     (key_s1),
		.push    (push)
	);

	hkrb_report_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== design/hkrb_engine.sv =====
// Report state and the press, release, release-all and tap update logic.
module hkrb_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  hkrb_pkg::req_t      req,
	input  logic [7:0]          key,
	output hkrb_pkg::push_t     push
);

	typedef logic [hkrb_pkg::SLOT_COUNT-1:0][7:0] slots_t;

	logic [7:0]      modifier_q;
	slots_t          slots_q;

	logic            is_mod;
	logic            is_upper;
	logic [7:0]      mod_bit;
	hkrb_pkg::usage_t u;
	logic            known;
	logic            stop;

	logic [7:0]      p_mod;
	slots_t          p_slots;
	logic [7:0]      rb_mod;
	slots_t          rb_slots;
	logic [7:0]      r_mod;
	slots_t          r_slots;
	logic [7:0]      n_mod;
	slots_t          n_slots;

	function automatic hkrb_pkg::report_t make_report(input logic [7:0] m, input slots_t s,
			input logic last);
		hkrb_pkg::report_t r;
		r.modifier = m;
		r.last     = last;
		r.slot     = '0;
		for (int j = 0; j < hkrb_pkg::SHOWN_SLOTS; j++) begin
			if (j < hkrb_pkg::SLOT_COUNT) begin
				r.slot[j] = s[j];
			end
		end
		return r;
	endfunction

	always_comb begin
		is_mod   = (key[7:3] == hkrb_pkg::MOD_CODE_HI);
		is_upper = key inside {[8'h41:8'h5A]};
		mod_bit  = 8'h01 << key[2:0];
		u        = hkrb_pkg::usage_of(key);
		known    = is_mod || (u != '0);

		// press: a modifier key sets its bit; otherwise the first empty slot takes the usage unless a copy is met first
		p_mod   = modifier_q;
		p_slots = slots_q;
		stop    = 1'b0;
		if (is_mod) begin
			p_mod = modifier_q | mod_bit;
		end else if (u != '0) begin
			if (is_upper) begin
				p_mod = modifier_q | hkrb_pkg::SHIFT_BIT;
			end
			for (int i = 0; i < hkrb_pkg::SLOT_COUNT; i++) begin
				if (!stop) begin
					if (slots_q[i] == '0) begin
						p_slots[i] = u;
						stop       = 1'b1;
					end else if (slots_q[i] == u) begin
						stop = 1'b1;
					end
				end
			end
		end

		// release: start from the press result on a tap
		rb_mod   = (req == hkrb_pkg::REQ_TAP) ? p_mod : modifier_q;
		rb_slots = (req == hkrb_pkg::REQ_TAP) ? p_slots : slots_q;
		r_mod    = rb_mod;
		r_slots  = rb_slots;
		if (is_mod) begin
			r_mod = rb_mod & ~mod_bit;
		end else if (u != '0) begin
			for (int i = 0; i < hkrb_pkg::SLOT_COUNT; i++) begin
				if (rb_slots[i] == u) begin
					r_slots[i] = '0;
				end
			end
		end

		push.second = make_report(r_mod, r_slots, 1'b1);
		case (req)
			hkrb_pkg::REQ_PRESS: begin
				n_mod      = p_mod;
				n_slots    = p_slots;
				push.n     = known ? 2'd1 : 2'd0;
				push.first = make_report(p_mod, p_slots, 1'b1);
			end
			hkrb_pkg::REQ_RELEASE: begin
				n_mod      = r_mod;
				n_slots    = r_slots;
				push.n     = known ? 2'd1 : 2'd0;
				push.first = make_report(r_mod, r_slots, 1'b1);
			end
			hkrb_pkg::REQ_RELEASE_ALL: begin
				n_mod      = '0;
				n_slots    = '0;
				push.n     = 2'd1;
				push.first = make_report(8'h00, '0, 1'b1);
			end
			default: begin
				n_mod      = r_mod;
				n_slots    = r_slots;
				push.n     = known ? 2'd2 : 2'd0;
				push.first = make_report(p_mod, p_slots, 1'b0);
			end
		endcase
		if (!advance) begin
			push.n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modifier_q <= '0;
			slots_q    <= '0;
		end else if (advance) begin
			modifier_q <= n_mod;
			slots_q    <= n_slots;
		end
	end

endmodule

// ===== design/hkrb_report_fifo.sv =====
// Report queue that takes up to two reports a cycle and hands one out per transfer.
`include "hid_keyboard_report_builder_top_macros.svh"

module hkrb_report_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  hkrb_pkg::push_t  push,
	output logic             room,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [55:0]      m_tdata,   // modifier_bits, slot0_usage .. slot5_usage
	output logic             m_tlast
);

	hkrb_pkg::report_t                  fifo_q [hkrb_pkg::REPORT_DEPTH];
	logic [hkrb_pkg::PTR_W-1:0]         wr_ptr_q;
	logic [hkrb_pkg::PTR_W-1:0]         rd_ptr_q;
	logic [hkrb_pkg::CNT_W-1:0]         count_q;
	logic                               pop;
	hkrb_pkg::report_t                  head;

	assign head     = fifo_q[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {head.slot, head.modifier};
	assign m_tlast  = head.last;
	assign pop      = m_tvalid && m_tready;
	assign room     = (count_q <= hkrb_pkg::CNT_W'(hkrb_pkg::REPORT_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			fifo_q[wr_ptr_q] <= push.first;
		end
		if (push.n == 2'd2) begin
			fifo_q[wr_ptr_q + hkrb_pkg::PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + hkrb_pkg::PTR_W'(push.n);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + hkrb_pkg::PTR_W'(1);
			end
			count_q <= count_q + hkrb_pkg::CNT_W'(push.n) - hkrb_pkg::CNT_W'(pop);
		end
	end

	`HKRB_ASSERT_ALWAYS(a_count_max, count_q <= hkrb_pkg::CNT_W'(hkrb_pkg::REPORT_DEPTH), "report queue count beyond depth")
	`HKRB_ASSERT(a_no_overflow, (push.n != 2'd0) |-> ((count_q + hkrb_pkg::CNT_W'(push.n)) <= hkrb_pkg::CNT_W'(hkrb_pkg::REPORT_DEPTH)), "report queue written while full")
	`HKRB_ASSERT(a_tap_order, (push.n == 2'd2) |-> (!push.first.last && push.second.last), "tap reports out of order")
	`HKRB_ASSERT(a_drain, (pop && (count_q == hkrb_pkg::CNT_W'(1)) && (push.n == 2'd0)) |=> !m_tvalid, "report queue not empty after last transfer")

endmodule
